### rtl/accumulating_integer_calculator_defines.svh
// assertion macros for the accumulating integer calculator
// expects aclk and aresetn in the scope where a macro is used
`ifndef ACCUMULATING_INTEGER_CALCULATOR_DEFINES_SVH
`define ACCUMULATING_INTEGER_CALCULATOR_DEFINES_SVH

// consequent checked in the same cycle as the trigger
`define AIC_ASSERT_SAME(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error(msg);

// consequent checked in the cycle after the trigger
`define AIC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

### rtl/aic_pkg.sv
// shared types and constants for the accumulating integer calculator
// no dependencies
package aic_pkg;

    localparam int DATA_WIDTH = 32;

    // operation codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_FACT = 3'd4,
        MODE_POW  = 3'd5
    } mode_t;

    // status codes of a result beat
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_NEG_EXP  = 2'd2
    } status_t;

    // input beat
    typedef struct packed {
        logic [2:0]                   mode;
        logic signed [DATA_WIDTH-1:0] first_operand;
        logic signed [DATA_WIDTH-1:0] second_operand;
        logic                         clear_after;
    } calc_in_t;

    // result beat
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        status_t                      status;
    } calc_out_t;

endpackage

### rtl/aic_addsub.sv
// shared adder/subtractor of the calculator datapath
// no dependencies; carry out doubles as not-borrow when subtracting
module aic_addsub #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] x_in,
    input  logic [WIDTH-1:0] y_in,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH-1:0] y_eff;

    // invert and add one for subtraction
    assign y_eff = sub ? ~y_in : y_in;
    assign {carry, sum} = {1'b0, x_in} + {1'b0, y_eff} + {{WIDTH{1'b0}}, sub};

endmodule

### rtl/accumulating_integer_calculator.sv
// Accumulating integer calculator, top level.
// Depends on aic_pkg, aic_addsub and accumulating_integer_calculator_defines.svh.
//
// Input channel s_valid/s_ready/s_data carries one operation per beat: mode, a
// first operand (used only while the accumulator is zero), a second operand and
// a clear request. Result channel m_valid/m_ready/m_data returns one beat per
// input beat with the wrapped value and a status code.
// All arithmetic runs through one add/subtract unit under a sequencer; the block
// takes one item at a time and s_ready is high only while the sequencer is idle.
// Sequence per mode (W = DATA_WIDTH = 32):
//   add, subtract: through the adder; errors and unused modes: straight to finish
//   multiply: shift-add, one multiplier bit per cycle
//   divide: restoring, one quotient bit per cycle, plus sign fixes
//   factorial n: a multiply by each factor, at most 2W + 1 factors
//   power: per exponent bit up to two W-bit multiplies
// Result beats sit in an output register; a stalled receiver holds the
// sequencer in its last step, and a new item is taken while a result waits.
// Reset (aresetn low, synchronous) clears the accumulator to zero, drops m_valid
// and returns the sequencer to idle.
`include "accumulating_integer_calculator_defines.svh"

module accumulating_integer_calculator
    import aic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  calc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output calc_out_t m_data
);

    localparam int W = DATA_WIDTH;
    localparam int CNT_W = $clog2(2 * W + 3);
    localparam logic [W-1:0] FACT_LIMIT = W'(2 * W + 2);
    localparam logic [W-1:0] ONE = W'(1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(W - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDSUB,
        S_MUL,
        S_MUL_RET,
        S_DIV_ABS_A,
        S_DIV_ABS_B,
        S_DIV_ITER,
        S_DIV_SIGN,
        S_FACT_STEP,
        S_FACT_RET,
        S_POW_STEP,
        S_POW_RMUL,
        S_POW_SQ_RET,
        S_FINISH
    } state_t;

    state_t           state_reg;
    state_t           ret_reg;
    logic [W-1:0]     acc_reg;
    logic [2:0]       mode_reg;
    logic             clr_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     mul_x_reg;
    logic [W-1:0]     mul_y_reg;
    logic [W-1:0]     prod_reg;
    logic [W-1:0]     res_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             ok_reg;
    status_t          status_reg;
    logic             m_valid_reg;
    calc_out_t        m_data_reg;

    logic [W-1:0]     a_work;
    logic [W-1:0]     b_in;
    logic [W-1:0]     div_shift;
    logic [W-1:0]     cnt_ext;
    logic [W-1:0]     add_x;
    logic [W-1:0]     add_y;
    logic             add_sub;
    logic [W-1:0]     add_sum;
    logic             add_cout;
    logic             res_fire;

    // working first value: accumulator unless it is zero
    assign a_work    = (acc_reg != '0) ? acc_reg : s_data.first_operand;
    assign b_in      = s_data.second_operand;
    assign div_shift = {rem_reg[W-2:0], a_reg[W-1]};
    assign cnt_ext   = {{(W - CNT_W){1'b0}}, cnt_reg};
    assign res_fire  = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // operand select for the shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_ADDSUB: begin
                add_x   = a_reg;
                add_y   = b_reg;
                add_sub = (mode_reg == MODE_SUB);
            end
            S_MUL: begin
                add_x = prod_reg;
                add_y = mul_x_reg;
            end
            S_DIV_ABS_A, S_DIV_SIGN: begin
                add_y   = a_reg;
                add_sub = 1'b1;
            end
            S_DIV_ABS_B: begin
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            S_DIV_ITER: begin
                add_x   = div_shift;
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    aic_addsub #(
        .WIDTH (W)
    ) u_addsub (
        .x_in  (add_x),
        .y_in  (add_y),
        .sub   (add_sub),
        .sum   (add_sum),
        .carry (add_cout)
    );

    // sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready && !res_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_data.mode;
                        clr_reg    <= s_data.clear_after;
                        a_reg      <= a_work;
                        b_reg      <= b_in;
                        rem_reg    <= '0;
                        cnt_reg    <= '0;
                        neg_reg    <= a_work[W-1] ^ b_in[W-1];
                        ok_reg     <= 1'b1;
                        status_reg <= STATUS_OK;
                        res_reg    <= ONE;
                        case (s_data.mode)
                            MODE_ADD, MODE_SUB: begin
                                state_reg <= S_ADDSUB;
                            end
                            MODE_MUL: begin
                                mul_x_reg <= a_work;
                                mul_y_reg <= b_in;
                                prod_reg  <= '0;
                                ret_reg   <= S_MUL_RET;
                                state_reg <= S_MUL;
                            end
                            MODE_DIV: begin
                                if (b_in == '0) begin
                                    ok_reg     <= 1'b0;
                                    status_reg <= STATUS_DIV_ZERO;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    state_reg <= S_DIV_ABS_A;
                                end
                            end
                            MODE_FACT: begin
                                cnt_reg <= CNT_ONE;
                                // zero gives one, negative gives itself, large wraps to zero
                                if (a_work == '0) begin
                                    state_reg <= S_FINISH;
                                end else if (a_work[W-1]) begin
                                    res_reg   <= a_work;
                                    state_reg <= S_FINISH;
                                end else if (a_work >= FACT_LIMIT) begin
                                    res_reg   <= '0;
                                    state_reg <= S_FINISH;
                                end else begin
                                    state_reg <= S_FACT_STEP;
                                end
                            end
                            MODE_POW: begin
                                if (b_in[W-1]) begin
                                    ok_reg     <= 1'b0;
                                    status_reg <= STATUS_NEG_EXP;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    state_reg <= S_POW_STEP;
                                end
                            end
                            default: begin
                                ok_reg    <= 1'b0;
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_ADDSUB: begin
                    res_reg   <= add_sum;
                    state_reg <= S_FINISH;
                end
                // shift-add multiply, stops once the multiplier runs out of ones
                S_MUL: begin
                    if (mul_y_reg == '0) begin
                        state_reg <= ret_reg;
                    end else begin
                        if (mul_y_reg[0]) begin
                            prod_reg <= add_sum;
                        end
                        mul_x_reg <= mul_x_reg << 1;
                        mul_y_reg <= mul_y_reg >> 1;
                    end
                end
                S_MUL_RET: begin
                    res_reg   <= prod_reg;
                    state_reg <= S_FINISH;
                end
                // divide on magnitudes, sign applied at the end
                S_DIV_ABS_A: begin
                    if (a_reg[W-1]) begin
                        a_reg <= add_sum;
                    end
                    state_reg <= S_DIV_ABS_B;
                end
                S_DIV_ABS_B: begin
                    if (b_reg[W-1]) begin
                        b_reg <= add_sum;
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_ITER;
                end
                S_DIV_ITER: begin
                    rem_reg <= add_cout ? add_sum : div_shift;
                    a_reg   <= {a_reg[W-2:0], add_cout};
                    cnt_reg <= cnt_reg + CNT_ONE;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= S_DIV_SIGN;
                    end
                end
                S_DIV_SIGN: begin
                    res_reg   <= neg_reg ? add_sum : a_reg;
                    state_reg <= S_FINISH;
                end
                // factorial: multiply the running product by k = 1..n
                S_FACT_STEP: begin
                    if (cnt_ext > a_reg) begin
                        state_reg <= S_FINISH;
                    end else begin
                        mul_x_reg <= res_reg;
                        mul_y_reg <= cnt_ext;
                        prod_reg  <= '0;
                        ret_reg   <= S_FACT_RET;
                        cnt_reg   <= cnt_reg + CNT_ONE;
                        state_reg <= S_MUL;
                    end
                end
                S_FACT_RET: begin
                    res_reg   <= prod_reg;
                    state_reg <= S_FACT_STEP;
                end
                // power by square and multiply, exponent bits from the bottom
                S_POW_STEP: begin
                    if (b_reg == '0) begin
                        state_reg <= S_FINISH;
                    end else if (b_reg[0]) begin
                        mul_x_reg <= res_reg;
                        mul_y_reg <= a_reg;
                        prod_reg  <= '0;
                        ret_reg   <= S_POW_RMUL;
                        state_reg <= S_MUL;
                    end else begin
                        mul_x_reg <= a_reg;
                        mul_y_reg <= a_reg;
                        prod_reg  <= '0;
                        ret_reg   <= S_POW_SQ_RET;
                        state_reg <= S_MUL;
                    end
                end
                S_POW_RMUL: begin
                    res_reg   <= prod_reg;
                    mul_x_reg <= a_reg;
                    mul_y_reg <= a_reg;
                    prod_reg  <= '0;
                    ret_reg   <= S_POW_SQ_RET;
                    state_reg <= S_MUL;
                end
                S_POW_SQ_RET: begin
                    a_reg     <= prod_reg;
                    b_reg     <= b_reg >> 1;
                    state_reg <= S_POW_STEP;
                end
                // deliver the result beat and, on success, update the accumulator
                S_FINISH: begin
                    if (res_fire) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.result_value <= ok_reg ? res_reg : acc_reg;
                        m_data_reg.status       <= status_reg;
                        if (ok_reg) begin
                            acc_reg <= clr_reg ? '0 : res_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks on accumulator handling and the sequencer
    `AIC_ASSERT_NEXT(a_acc_hold, !res_fire, $stable(acc_reg), "accumulator changed between results")
    `AIC_ASSERT_NEXT(a_err_shows_acc, res_fire && !ok_reg, m_data.result_value == acc_reg, "error beat does not show accumulator")
    `AIC_ASSERT_NEXT(a_clear_acc, res_fire && ok_reg && clr_reg, acc_reg == '0, "clear request not applied")
    `AIC_ASSERT_SAME(a_err_status, res_fire && status_reg != STATUS_OK, !ok_reg, "error status on a successful result")
    `AIC_ASSERT_SAME(a_div_count, state_reg == S_DIV_ITER, cnt_reg <= DIV_LAST, "divide step count overrun")

endmodule

### test/calc_result_checker.sv
// result checker for the accumulating integer calculator: watches both channels,
// keeps its own accumulator, predicts each result beat and compares it
// depends on aic_pkg for the beat types, mode and status codes
module calc_result_checker
    import aic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  calc_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  calc_out_t m_data,
    output int        fail_count,
    output int        results_pending,
    output int        results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = DATA_WIDTH;

    logic [W-1:0] acc_model;
    calc_out_t    predicted_results[$];
    int           mismatch_count = 0;
    int           checked_count = 0;

    assign fail_count      = mismatch_count;
    assign results_checked = checked_count;

    // one line per mismatch
    task automatic report_mismatch(input string what, input calc_out_t got,
                                   input calc_out_t want);
        $display("[%0t] mismatch (%s): got value %h status %0d, want value %h status %0d",
                 $realtime, what, got.result_value, got.status,
                 want.result_value, want.status);
        mismatch_count = mismatch_count + 1;
    endtask

    // compute the result of one operation and advance the accumulator
    task automatic evaluate_op(input calc_in_t beat, output calc_out_t res);
        logic [W-1:0] lhs;
        logic [W-1:0] rhs;
        logic [W-1:0] val;
        logic [W-1:0] mag_l;
        logic [W-1:0] mag_r;
        logic [W-1:0] quot;
        logic [W-1:0] base;
        logic [W-1:0] exp_bits;
        logic [W-1:0] factor;
        status_t      st;
        bit           ok;
        // stored accumulator wins over the fresh first operand while nonzero
        lhs = (acc_model != '0) ? acc_model : beat.first_operand;
        rhs = beat.second_operand;
        val = '0;
        st  = STATUS_OK;
        ok  = 1'b1;
        case (beat.mode)
            MODE_ADD: val = lhs + rhs;
            MODE_SUB: val = lhs - rhs;
            MODE_MUL: val = lhs * rhs;
            MODE_DIV: begin
                if (rhs == '0) begin
                    st = STATUS_DIV_ZERO;
                    ok = 1'b0;
                end else begin
                    // truncate toward zero on magnitudes, sign fixed afterwards
                    mag_l = lhs[W-1] ? -lhs : lhs;
                    mag_r = rhs[W-1] ? -rhs : rhs;
                    quot  = mag_l / mag_r;
                    val   = (lhs[W-1] != rhs[W-1]) ? -quot : quot;
                end
            end
            MODE_FACT: begin
                if (lhs == '0) begin
                    val = 1;
                end else if (lhs[W-1]) begin
                    val = lhs;
                end else if (lhs >= 2 * W + 2) begin
                    // enough factors of two to wrap the product to zero
                    val = '0;
                end else begin
                    val = 1;
                    for (factor = 1; factor <= lhs; factor++) val = val * factor;
                end
            end
            MODE_POW: begin
                if (rhs[W-1]) begin
                    st = STATUS_NEG_EXP;
                    ok = 1'b0;
                end else begin
                    // square and multiply, wrapping at every step
                    val      = 1;
                    base     = lhs;
                    exp_bits = rhs;
                    while (exp_bits != '0) begin
                        if (exp_bits[0]) val = val * base;
                        base     = base * base;
                        exp_bits = exp_bits >> 1;
                    end
                end
            end
            default: ok = 1'b0;
        endcase
        // errors and unused codes keep the accumulator and show it
        if (ok) begin
            acc_model = beat.clear_after ? '0 : val;
        end else begin
            val = acc_model;
        end
        res.result_value = val;
        res.status       = st;
    endtask

    // result beats are matched before the input beat of the same cycle is added
    always @(posedge aclk) begin : watch
        calc_out_t want;
        calc_out_t got;
        if (!aresetn) begin
            acc_model = '0;
            predicted_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (predicted_results.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected result beat", got, want);
                end else begin
                    want = predicted_results.pop_front();
                    checked_count = checked_count + 1;
                    if (got.result_value !== want.result_value)
                        report_mismatch("result_value", got, want);
                    if (got.status !== want.status)
                        report_mismatch("status", got, want);
                end
            end
            if (s_valid && s_ready) begin
                evaluate_op(s_data, want);
                predicted_results.push_back(want);
            end
        end
        results_pending <= predicted_results.size();
    end

endmodule

### test/testbench.sv
// top of the accumulating integer calculator testbench: clock, reset, stimulus
// and verdict; depends on aic_pkg, the calculator RTL and calc_result_checker
module testbench
    import aic_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = DATA_WIDTH;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int DRAIN_CYCLES = 64;
    // power with a full exponent is the longest operation; allow that for every beat
    localparam longint CYCLE_LIMIT = 12_000_000;

    // unused mode codes, computed as a no-op
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MINUS_ONE = '1;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    calc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    calc_out_t m_data;

    int        fail_count;
    int        results_pending;
    int        results_checked;
    int        send_idle_pct = 0;
    int        ready_idle_pct = 0;
    int        beats_sent = 0;
    longint    cycle_count = 0;

    accumulating_integer_calculator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    calc_result_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one input beat, with a random gap ahead of it; returns at the accepting edge
    task automatic send_beat(input calc_in_t beat);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent = beats_sent + 1;
    endtask

    task automatic issue_op(input logic [2:0] mode, input logic [W-1:0] a,
                            input logic [W-1:0] b, input logic clr);
        calc_in_t beat;
        beat.mode           = mode;
        beat.first_operand  = a;
        beat.second_operand = b;
        beat.clear_after    = clr;
        send_beat(beat);
    endtask

    // operand mix: extremes, small values, full range
    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 1;
                    2: return MINUS_ONE;
                    3: return MAX_POS;
                    default: return MIN_NEG;
                endcase
            end
            1, 2: return W'($urandom_range(0, 40)) - W'(20);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_op();
        logic [2:0]   mode;
        logic [W-1:0] a;
        logic [W-1:0] b;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 16)      mode = MODE_ADD;
        else if (pick < 32) mode = MODE_SUB;
        else if (pick < 48) mode = MODE_MUL;
        else if (pick < 64) mode = MODE_DIV;
        else if (pick < 76) mode = MODE_FACT;
        else if (pick < 94) mode = MODE_POW;
        else if (pick < 97) mode = MODE_UNUSED_6;
        else                mode = MODE_UNUSED_7;
        a = pick_operand();
        b = pick_operand();
        // factorial mostly on small values so the interesting range is hit
        if (mode == MODE_FACT && $urandom_range(0, 9) < 7)
            a = W'($urandom_range(0, 70));
        if (mode == MODE_DIV && $urandom_range(0, 99) < 8)
            b = '0;
        // exponents mostly small; a few full-range ones, half of them negative
        if (mode == MODE_POW) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       b = $urandom;
            else if (pick < 15) b = -W'($urandom_range(1, 40));
            else                b = W'($urandom_range(0, 40));
        end
        issue_op(mode, a, b, $urandom_range(0, 99) < 35);
    endtask

    initial begin
        send_idle_pct  = 31;
        ready_idle_pct = 68;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wrap edges, error paths, unused codes, factorial and power corners
        issue_op(MODE_ADD, MAX_POS, 1, 1'b0);
        issue_op(MODE_SUB, 5, 1, 1'b1);
        issue_op(MODE_MUL, MIN_NEG, MINUS_ONE, 1'b1);
        issue_op(MODE_DIV, MIN_NEG, MINUS_ONE, 1'b0);
        issue_op(MODE_DIV, 9, '0, 1'b1);
        issue_op(MODE_POW, 2, MINUS_ONE, 1'b1);
        issue_op(MODE_POW, 2, MIN_NEG, 1'b1);
        issue_op(MODE_UNUSED_6, 3, 4, 1'b1);
        issue_op(MODE_UNUSED_7, MAX_POS, MIN_NEG, 1'b1);
        issue_op(MODE_ADD, '0, MIN_NEG, 1'b0);
        issue_op(MODE_FACT, '0, MAX_POS, 1'b1);
        issue_op(MODE_FACT, -W'(5), '0, 1'b1);
        issue_op(MODE_FACT, 12, '0, 1'b1);
        issue_op(MODE_FACT, 33, '0, 1'b1);
        issue_op(MODE_FACT, 34, '0, 1'b1);
        issue_op(MODE_FACT, 65, '0, 1'b1);
        issue_op(MODE_FACT, 66, '0, 1'b1);
        issue_op(MODE_FACT, MAX_POS, '0, 1'b1);
        issue_op(MODE_POW, '0, '0, 1'b1);
        issue_op(MODE_POW, -W'(2), 31, 1'b1);
        issue_op(MODE_POW, 3, MAX_POS, 1'b1);
        issue_op(MODE_DIV, 7, -W'(2), 1'b1);
        issue_op(MODE_DIV, -W'(7), 2, 1'b0);
        issue_op(MODE_DIV, 100, MAX_POS, 1'b0);
        issue_op(MODE_MUL, MAX_POS, MAX_POS, 1'b0);

        // random: sender light/receiver heavy, then swapped, then no idling
        repeat (RANDOM_PER_PHASE) random_op();
        send_idle_pct  = 68;
        ready_idle_pct = 31;
        repeat (RANDOM_PER_PHASE) random_op();
        send_idle_pct  = 0;
        ready_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) random_op();
        s_valid <= 1'b0;

        // drain, then a short tail for stray beats
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operation beats, %0d results checked: all six modes, unused codes,",
                 beats_sent, results_checked);
        $display("error paths and accumulator carry-over under three sender/receiver idle mixes");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/aic_pkg.sv
rtl/aic_addsub.sv
rtl/accumulating_integer_calculator.sv
test/calc_result_checker.sv
test/testbench.sv
